// ===== rtl/crast_pkg.sv =====
// ----------------------------------------------------------------------------
// crast_pkg: shared types and constants of the circle rasterizer canvas
// Sizes, command and register codes, sequencer states, and the request and
// response records of the shared squaring unit.
// ----------------------------------------------------------------------------
package crast_pkg;

   // canvas geometry and number formats
   localparam int MAX_SIDE    = 256;
   localparam int FRAC_BITS   = 8;
   localparam int SIDE_W      = $clog2(MAX_SIDE);
   localparam int ADDR_W      = 2 * SIDE_W;
   localparam int DEPTH       = MAX_SIDE * MAX_SIDE;
   localparam int CSR_SIDE_W  = 9;
   localparam int CSR_DATA_W  = 9;
   localparam int CSR_INDEX_W = 2;
   localparam int CHAR_W      = 8;
   localparam int COORD_W     = 20;
   localparam int RADIUS_W    = 20;
   localparam int PIX_W       = SIDE_W + FRAC_BITS + 1;
   localparam int OPND_W      = ((COORD_W > PIX_W) ? COORD_W : PIX_W) + 1;
   localparam int MAG_W       = OPND_W - 1;
   localparam int SQ_W        = 2 * MAG_W;
   localparam int DIST_W      = SQ_W + 1;
   localparam int ONE_FIX     = 1 << FRAC_BITS;

   // reset values of the registers
   localparam logic [CSR_SIDE_W-1:0] WIDTH_RESET      = CSR_SIDE_W'(MAX_SIDE);
   localparam logic [CSR_SIDE_W-1:0] HEIGHT_RESET     = CSR_SIDE_W'(MAX_SIDE);
   localparam logic [CHAR_W-1:0]     BACKGROUND_RESET = CHAR_W'(32);

   typedef enum logic [1:0] {
      CMD_CLEAR   = 2'd0,
      CMD_OUTLINE = 2'd1,
      CMD_FILL    = 2'd2,
      CMD_READ    = 2'd3
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WIDTH      = 2'd0,
      CSR_HEIGHT     = 2'd1,
      CSR_BACKGROUND = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SQ_OUTER,
      ST_SQ_INNER,
      ST_ROW_SQ,
      ST_SCAN,
      ST_DRAIN,
      ST_READ,
      ST_RESP
   } state_type;

   // what a squaring result is used for
   typedef enum logic [2:0] {
      TAG_NONE,
      TAG_OUTER,
      TAG_INNER,
      TAG_DY,
      TAG_PIXEL
   } sq_tag_type;

   typedef struct packed {
      sq_tag_type               tag;
      logic [ADDR_W-1:0]        addr;
      logic signed [OPND_W-1:0] operand;
   } sq_req_type;

   typedef struct packed {
      sq_tag_type        tag;
      logic [ADDR_W-1:0] addr;
      logic [SQ_W-1:0]   square;
   } sq_rsp_type;

   // last usable index of a side, with 0 taken as 1 and large sizes clamped
   function automatic logic [SIDE_W-1:0] last_index(input logic [CSR_SIDE_W-1:0] side);
      logic [SIDE_W-1:0] result;
      if (side == '0) begin
         result = '0;
      end else if (side >= CSR_SIDE_W'(MAX_SIDE)) begin
         result = SIDE_W'(MAX_SIDE - 1);
      end else begin
         result = SIDE_W'(side - 1'b1);
      end
      return result;
   endfunction

endpackage

// ===== rtl/crast_squarer.sv =====
// ----------------------------------------------------------------------------
// crast_squarer: shared squaring unit
// Takes a signed operand, squares its magnitude and registers the result
// together with a tag and a pixel address that say what the square is for.
// ----------------------------------------------------------------------------
module crast_squarer (
   input  logic                   clock,
   input  logic                   reset,
   input  crast_pkg::sq_req_type  req,
   output crast_pkg::sq_rsp_type  rsp
);

   logic [crast_pkg::MAG_W-1:0]  mag;
   logic [crast_pkg::SQ_W-1:0]   square_in;
   logic [crast_pkg::SQ_W-1:0]   square_ff;
   logic [crast_pkg::ADDR_W-1:0] addr_ff;
   crast_pkg::sq_tag_type        tag_ff;

   // magnitude and square
   always_comb begin
      if (req.operand[crast_pkg::OPND_W-1]) begin
         mag = crast_pkg::MAG_W'(-req.operand);
      end else begin
         mag = crast_pkg::MAG_W'(req.operand);
      end
      square_in = crast_pkg::SQ_W'(mag) * crast_pkg::SQ_W'(mag);
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= crast_pkg::TAG_NONE;
      end else begin
         tag_ff <= req.tag;
      end
      addr_ff   <= req.addr;
      square_ff <= square_in;
   end

   assign rsp.tag    = tag_ff;
   assign rsp.addr   = addr_ff;
   assign rsp.square = square_ff;

endmodule

// ===== rtl/circle_rasterizer_canvas_core.sv =====
// ----------------------------------------------------------------------------
// circle_rasterizer_canvas_core: character canvas with circle rasterization
// Clear, outline circle, filled circle and pixel read commands on a
// 256 x 256 character store, with a squared-distance test per pixel.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy stays high
// until the command is finished. A clear makes one store write per cycle
// over the clamped width and height. An outline or filled circle first
// squares the radii, then for each row squares the row distance and scans
// its pixels, and ends with a pipeline tail; one squaring unit handles one
// pixel per cycle while a row is scanned. A read shows its result on the
// rsp_ ports for one cycle, after the store read and the result register,
// marked by rsp_valid; the receiver cannot stall it. Clear and draw commands
// give no result. The canvas store has no reset: a clear must come before
// reads, and a pixel never written reads as an arbitrary character. Registers
// are to be written only while busy is low; the block does not enforce this.
// ----------------------------------------------------------------------------
module circle_rasterizer_canvas_core (
   input  logic                               clock,
   input  logic                               reset,
   // command transfer
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_cmd,
   input  logic signed [crast_pkg::COORD_W-1:0] req_center_x,
   input  logic signed [crast_pkg::COORD_W-1:0] req_center_y,
   input  logic [crast_pkg::RADIUS_W-1:0]     req_radius,
   input  logic [crast_pkg::CHAR_W-1:0]       req_draw_char,
   input  logic [crast_pkg::SIDE_W-1:0]       req_read_col,
   input  logic [crast_pkg::SIDE_W-1:0]       req_read_row,
   // read result
   output logic                               rsp_valid,
   output logic [crast_pkg::CHAR_W-1:0]       rsp_pixel_char,
   output logic                               rsp_outside_canvas,
   // register writes
   input  logic                               csr_write_enable,
   input  logic [crast_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [crast_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   // registers
   logic [crast_pkg::CSR_SIDE_W-1:0] width_ff;
   logic [crast_pkg::CSR_SIDE_W-1:0] height_ff;
   logic [crast_pkg::CHAR_W-1:0]     background_ff;

   // sequencer and command context
   crast_pkg::state_type                 state_ff, state_in;
   logic [crast_pkg::SIDE_W-1:0]         col_ff, col_in;
   logic [crast_pkg::SIDE_W-1:0]         row_ff, row_in;
   logic signed [crast_pkg::COORD_W-1:0] cx_ff, cx_in;
   logic signed [crast_pkg::COORD_W-1:0] cy_ff, cy_in;
   logic [crast_pkg::RADIUS_W-1:0]       radius_ff, radius_in;
   logic [crast_pkg::CHAR_W-1:0]         char_ff, char_in;
   logic                                 has_inner_ff, has_inner_in;
   logic [crast_pkg::ADDR_W-1:0]         read_addr_ff, read_addr_in;
   logic                                 outside_ff, outside_in;
   logic [crast_pkg::SQ_W-1:0]           outer_ff, outer_in;
   logic [crast_pkg::SQ_W-1:0]           inner_ff, inner_in;
   logic [crast_pkg::SQ_W-1:0]           dy2_ff, dy2_in;

   // result registers
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [crast_pkg::CHAR_W-1:0]         rsp_char_ff, rsp_char_in;
   logic                                 rsp_outside_ff, rsp_outside_in;

   // canvas store
   logic [crast_pkg::CHAR_W-1:0] canvas_mem_ff [crast_pkg::DEPTH];
   logic [crast_pkg::CHAR_W-1:0] rdata_ff;
   logic                         mem_we;
   logic [crast_pkg::ADDR_W-1:0] mem_waddr;
   logic [crast_pkg::CHAR_W-1:0] mem_wdata;
   logic                         mem_re;

   // squaring unit
   crast_pkg::sq_req_type sq_req;
   crast_pkg::sq_rsp_type sq_rsp;

   logic                          accept;
   logic                          last_col_hit;
   logic                          last_row_hit;
   logic [crast_pkg::SIDE_W-1:0]  last_col;
   logic [crast_pkg::SIDE_W-1:0]  last_row;
   logic [crast_pkg::DIST_W-1:0]  dist2;
   logic                          pixel_hit;

   assign last_col     = crast_pkg::last_index(width_ff);
   assign last_row     = crast_pkg::last_index(height_ff);
   assign last_col_hit = (col_ff == last_col);
   assign last_row_hit = (row_ff == last_row);
   assign accept       = start && (state_ff == crast_pkg::ST_IDLE);

   crast_squarer u_squarer (
      .clock (clock),
      .reset (reset),
      .req   (sq_req),
      .rsp   (sq_rsp)
   );

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= crast_pkg::WIDTH_RESET;
         height_ff     <= crast_pkg::HEIGHT_RESET;
         background_ff <= crast_pkg::BACKGROUND_RESET;
      end else if (csr_write_enable) begin
         case (crast_pkg::csr_index_type'(csr_index))
            crast_pkg::CSR_WIDTH:      width_ff      <= csr_write_data;
            crast_pkg::CSR_HEIGHT:     height_ff     <= csr_write_data;
            crast_pkg::CSR_BACKGROUND: background_ff <= crast_pkg::CHAR_W'(csr_write_data);
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         crast_pkg::ST_IDLE: begin
            if (accept) begin
               case (crast_pkg::cmd_type'(req_cmd))
                  crast_pkg::CMD_CLEAR:   state_in = crast_pkg::ST_CLEAR;
                  crast_pkg::CMD_OUTLINE,
                  crast_pkg::CMD_FILL:    state_in = crast_pkg::ST_SQ_OUTER;
                  crast_pkg::CMD_READ:    state_in = crast_pkg::ST_READ;
                  default:                state_in = crast_pkg::ST_IDLE;
               endcase
            end
         end
         crast_pkg::ST_CLEAR: begin
            if (last_col_hit && last_row_hit) begin
               state_in = crast_pkg::ST_IDLE;
            end
         end
         crast_pkg::ST_SQ_OUTER: state_in = crast_pkg::ST_SQ_INNER;
         crast_pkg::ST_SQ_INNER: state_in = crast_pkg::ST_ROW_SQ;
         crast_pkg::ST_ROW_SQ:   state_in = crast_pkg::ST_SCAN;
         crast_pkg::ST_SCAN: begin
            if (last_col_hit) begin
               state_in = last_row_hit ? crast_pkg::ST_DRAIN : crast_pkg::ST_ROW_SQ;
            end
         end
         crast_pkg::ST_DRAIN: state_in = crast_pkg::ST_IDLE;
         crast_pkg::ST_READ:  state_in = crast_pkg::ST_RESP;
         crast_pkg::ST_RESP:  state_in = crast_pkg::ST_IDLE;
         default:             state_in = crast_pkg::ST_IDLE;
      endcase
   end

   // distance test of the pixel leaving the squaring unit
   assign dist2     = crast_pkg::DIST_W'(dy2_ff) + crast_pkg::DIST_W'(sq_rsp.square);
   assign pixel_hit = (dist2 <= crast_pkg::DIST_W'(outer_ff)) &&
                      (!has_inner_ff || (dist2 >= crast_pkg::DIST_W'(inner_ff)));

   // sequencer outputs: squaring requests and store ports
   always_comb begin
      busy           = (state_ff != crast_pkg::ST_IDLE);
      sq_req.tag     = crast_pkg::TAG_NONE;
      sq_req.addr    = {row_ff, col_ff};
      sq_req.operand = '0;
      mem_re         = (state_ff == crast_pkg::ST_READ);
      mem_we         = 1'b0;
      mem_waddr      = sq_rsp.addr;
      mem_wdata      = char_ff;
      case (state_ff)
         crast_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = {row_ff, col_ff};
            mem_wdata = background_ff;
         end
         crast_pkg::ST_SQ_OUTER: begin
            sq_req.tag     = crast_pkg::TAG_OUTER;
            sq_req.operand = crast_pkg::OPND_W'(radius_ff);
         end
         crast_pkg::ST_SQ_INNER: begin
            sq_req.tag     = crast_pkg::TAG_INNER;
            sq_req.operand = crast_pkg::OPND_W'(radius_ff) -
                             crast_pkg::OPND_W'(crast_pkg::ONE_FIX);
         end
         crast_pkg::ST_ROW_SQ: begin
            sq_req.tag     = crast_pkg::TAG_DY;
            sq_req.operand = crast_pkg::OPND_W'(cy_ff) -
                             (crast_pkg::OPND_W'(row_ff) << crast_pkg::FRAC_BITS);
         end
         crast_pkg::ST_SCAN: begin
            sq_req.tag     = crast_pkg::TAG_PIXEL;
            sq_req.operand = crast_pkg::OPND_W'(cx_ff) -
                             (crast_pkg::OPND_W'(col_ff) << crast_pkg::FRAC_BITS);
         end
         default: ;
      endcase
      // painting of a covered pixel as its square leaves the squaring unit, in the cycle after its scan
      if ((sq_rsp.tag == crast_pkg::TAG_PIXEL) && pixel_hit) begin
         mem_we = 1'b1;
      end
   end

   // datapath next values
   always_comb begin
      col_in         = col_ff;
      row_in         = row_ff;
      cx_in          = cx_ff;
      cy_in          = cy_ff;
      radius_in      = radius_ff;
      char_in        = char_ff;
      has_inner_in   = has_inner_ff;
      read_addr_in   = read_addr_ff;
      outside_in     = outside_ff;
      outer_in       = outer_ff;
      inner_in       = inner_ff;
      dy2_in         = dy2_ff;
      rsp_valid_in   = 1'b0;
      rsp_char_in    = rsp_char_ff;
      rsp_outside_in = rsp_outside_ff;

      // command capture
      if (accept) begin
         col_in       = '0;
         row_in       = '0;
         cx_in        = req_center_x;
         cy_in        = req_center_y;
         radius_in    = req_radius;
         char_in      = req_draw_char;
         has_inner_in = (req_cmd == crast_pkg::CMD_OUTLINE) &&
                        (req_radius >= crast_pkg::RADIUS_W'(crast_pkg::ONE_FIX));
         read_addr_in = {req_read_row, req_read_col};
         outside_in   = (req_read_col > last_col) || (req_read_row > last_row);
      end

      // raster walk over the canvas
      if ((state_ff == crast_pkg::ST_CLEAR) || (state_ff == crast_pkg::ST_SCAN)) begin
         if (last_col_hit) begin
            col_in = '0;
            row_in = row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end

      // squares that set up the distance test
      case (sq_rsp.tag)
         crast_pkg::TAG_OUTER: outer_in = sq_rsp.square;
         crast_pkg::TAG_INNER: inner_in = sq_rsp.square;
         crast_pkg::TAG_DY:    dy2_in   = sq_rsp.square;
         default: ;
      endcase

      // read result
      if (state_ff == crast_pkg::ST_RESP) begin
         rsp_valid_in   = 1'b1;
         rsp_outside_in = outside_ff;
         rsp_char_in    = outside_ff ? '0 : rdata_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= crast_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      col_ff         <= col_in;
      row_ff         <= row_in;
      cx_ff          <= cx_in;
      cy_ff          <= cy_in;
      radius_ff      <= radius_in;
      char_ff        <= char_in;
      has_inner_ff   <= has_inner_in;
      read_addr_ff   <= read_addr_in;
      outside_ff     <= outside_in;
      outer_ff       <= outer_in;
      inner_ff       <= inner_in;
      dy2_ff         <= dy2_in;
      rsp_char_ff    <= rsp_char_in;
      rsp_outside_ff <= rsp_outside_in;
   end

   // canvas store: one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         canvas_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= canvas_mem_ff[read_addr_ff];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pixel_char     = rsp_char_ff;
   assign rsp_outside_canvas = rsp_outside_ff;

endmodule

// ===== rtl/crast_checker.sv =====
// ----------------------------------------------------------------------------
// crast_checker: port-level checks of the circle rasterizer canvas
// Watches the command and result ports for read latency, result count and
// reset behavior; bound to the top level below.
// ----------------------------------------------------------------------------
module crast_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic [1:0]                        req_cmd,
   input logic                              rsp_valid,
   input logic [crast_pkg::CHAR_W-1:0]      rsp_pixel_char,
   input logic                              rsp_outside_canvas
);

   logic cmd_transfer;
   logic read_transfer;

   assign cmd_transfer  = start && !busy;
   assign read_transfer = cmd_transfer && (req_cmd == crast_pkg::CMD_READ);

   // a read transfer is followed by its result
   a_read_latency: assert property (@(posedge clock) disable iff (reset)
      read_transfer |-> ##3 rsp_valid)
      else $error("read result missing three cycles after transfer");

   // clear and draw commands give no result
   a_no_result: assert property (@(posedge clock) disable iff (reset)
      (cmd_transfer && !read_transfer) |=> !rsp_valid)
      else $error("result after a clear or draw command");

   // a result follows a busy period and lasts one cycle
   a_result_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) && !busy))
      else $error("result not at the end of a busy period");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // reset leaves the block idle with no result
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid))
      else $error("block not idle after reset");

endmodule

bind circle_rasterizer_canvas_core crast_checker u_crast_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .req_cmd            (req_cmd),
   .rsp_valid          (rsp_valid),
   .rsp_pixel_char     (rsp_pixel_char),
   .rsp_outside_canvas (rsp_outside_canvas)
);

// ===== tb/circle_canvas_checker.sv =====
// ----------------------------------------------------------------------------
// circle_canvas_checker: canvas predictor and read result checker
// Watches register writes and command transfers, keeps its own copy of the
// character canvas, predicts every pixel read and compares each rsp_ transfer
// with the oldest pending read, field by field.
// ----------------------------------------------------------------------------
module circle_canvas_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   // command channel
   input  logic                                 start,
   input  logic                                 busy,
   input  logic [1:0]                           req_cmd,
   input  logic signed [crast_pkg::COORD_W-1:0] req_center_x,
   input  logic signed [crast_pkg::COORD_W-1:0] req_center_y,
   input  logic [crast_pkg::RADIUS_W-1:0]       req_radius,
   input  logic [crast_pkg::CHAR_W-1:0]         req_draw_char,
   input  logic [crast_pkg::SIDE_W-1:0]         req_read_col,
   input  logic [crast_pkg::SIDE_W-1:0]         req_read_row,
   // read results
   input  logic                                 rsp_valid,
   input  logic [crast_pkg::CHAR_W-1:0]         rsp_pixel_char,
   input  logic                                 rsp_outside_canvas,
   // register writes
   input  logic                                 csr_write_enable,
   input  logic [crast_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [crast_pkg::CSR_DATA_W-1:0]     csr_write_data,
   // status for the stimulus side
   output int                                   error_count,
   output int                                   reads_pending,
   output int                                   canvas_cols,
   output int                                   canvas_rows
);
   import crast_pkg::*;

   localparam int PRINT_LIMIT = 40;

   typedef struct packed {
      logic [CHAR_W-1:0] pixel_char;
      logic              outside_canvas;
   } pixel_read;

   pixel_read             expected_reads[$];
   logic [CHAR_W-1:0]     canvas_chars [DEPTH];
   logic [CSR_SIDE_W-1:0] width_reg;
   logic [CSR_SIDE_W-1:0] height_reg;
   logic [CHAR_W-1:0]     background_reg;
   int                    mismatches = 0;

   // side in use: zero counts as one, large sizes stop at the store size
   function automatic int used_side(input logic [CSR_SIDE_W-1:0] side);
      if (side == '0) return 1;
      if (side > CSR_SIDE_W'(MAX_SIDE)) return MAX_SIDE;
      return int'(side);
   endfunction

   task automatic flag_mismatch(input string what);
      if (mismatches < PRINT_LIMIT) $display("%0t: mismatch: %s", $time, what);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch
      pixel_read want;
      longint    cx, cy, rad, outer, inner, dx, dy, d2;
      bit        has_inner;
      int        cols, rows;

      if (reset) begin
         width_reg      = WIDTH_RESET;
         height_reg     = HEIGHT_RESET;
         background_reg = BACKGROUND_RESET;
         expected_reads.delete();
      end else begin
         cols = used_side(width_reg);
         rows = used_side(height_reg);

         // result transfer against the oldest pending read
         if (rsp_valid) begin
            if (expected_reads.size() == 0) begin
               flag_mismatch($sformatf("result char %02h outside %0b with no read pending",
                                       rsp_pixel_char, rsp_outside_canvas));
            end else begin
               want = expected_reads.pop_front();
               if (rsp_pixel_char !== want.pixel_char)
                  flag_mismatch($sformatf("pixel_char %02h, expected %02h",
                                          rsp_pixel_char, want.pixel_char));
               if (rsp_outside_canvas !== want.outside_canvas)
                  flag_mismatch($sformatf("outside_canvas %0b, expected %0b",
                                          rsp_outside_canvas, want.outside_canvas));
            end
         end

         // command transfer
         if (start && !busy) begin
            case (cmd_type'(req_cmd))
               CMD_CLEAR: begin
                  for (int row = 0; row < rows; row++)
                     for (int col = 0; col < cols; col++)
                        canvas_chars[row * MAX_SIDE + col] = background_reg;
               end
               CMD_OUTLINE, CMD_FILL: begin
                  // squared distance test per pixel, ring when outlining
                  cx        = longint'(req_center_x);
                  cy        = longint'(req_center_y);
                  rad       = longint'(req_radius);
                  outer     = rad * rad;
                  has_inner = (cmd_type'(req_cmd) == CMD_OUTLINE) && (rad >= ONE_FIX);
                  inner     = has_inner ? (rad - ONE_FIX) * (rad - ONE_FIX) : 0;
                  for (int row = 0; row < rows; row++) begin
                     dy = cy - (longint'(row) <<< FRAC_BITS);
                     for (int col = 0; col < cols; col++) begin
                        dx = cx - (longint'(col) <<< FRAC_BITS);
                        d2 = dy * dy + dx * dx;
                        if (d2 <= outer && (!has_inner || d2 >= inner))
                           canvas_chars[row * MAX_SIDE + col] = req_draw_char;
                     end
                  end
               end
               default: begin
                  if (int'(req_read_col) >= cols || int'(req_read_row) >= rows) begin
                     want.pixel_char     = '0;
                     want.outside_canvas = 1'b1;
                  end else begin
                     want.pixel_char     = canvas_chars[int'(req_read_row) * MAX_SIDE
                                                        + int'(req_read_col)];
                     want.outside_canvas = 1'b0;
                  end
                  expected_reads.push_back(want);
               end
            endcase
         end

         // register writes, unknown indexes change nothing
         if (csr_write_enable) begin
            case (csr_index)
               CSR_WIDTH:      width_reg      = csr_write_data[CSR_SIDE_W-1:0];
               CSR_HEIGHT:     height_reg     = csr_write_data[CSR_SIDE_W-1:0];
               CSR_BACKGROUND: background_reg = csr_write_data[CHAR_W-1:0];
               default: ;
            endcase
         end
      end

      error_count   <= mismatches;
      reads_pending <= expected_reads.size();
      canvas_cols   <= used_side(width_reg);
      canvas_rows   <= used_side(height_reg);
   end

endmodule

// ===== tb/tb_circle_rasterizer_canvas_core.sv =====
// ----------------------------------------------------------------------------
// tb_circle_rasterizer_canvas_core: testbench top of the circle rasterizer
// Drives clear, outline, fill and read commands and register writes: a short
// directed part on extreme sizes, radii and centres, then random phases with
// random canvas settings. The checker beside the block predicts every read.
// ----------------------------------------------------------------------------
module tb_circle_rasterizer_canvas_core;
   import crast_pkg::*;

   localparam int CYCLE_LIMIT  = 1_500_000;
   localparam int RANDOM_ITEMS = 100;
   localparam int TAIL_CYCLES  = 4;
   // register index with no register behind it
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct {
      cmd_type                   cmd;
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic [RADIUS_W-1:0]       radius;
      logic [CHAR_W-1:0]         draw_char;
      logic [SIDE_W-1:0]         read_col;
      logic [SIDE_W-1:0]         read_row;
   } canvas_command;

   logic                       clock              = 1'b0;
   logic                       reset              = 1'b1;
   logic                       start              = 1'b0;
   logic                       busy;
   logic [1:0]                 req_cmd            = '0;
   logic signed [COORD_W-1:0]  req_center_x       = '0;
   logic signed [COORD_W-1:0]  req_center_y       = '0;
   logic [RADIUS_W-1:0]        req_radius         = '0;
   logic [CHAR_W-1:0]          req_draw_char      = '0;
   logic [SIDE_W-1:0]          req_read_col       = '0;
   logic [SIDE_W-1:0]          req_read_row       = '0;
   logic                       rsp_valid;
   logic [CHAR_W-1:0]          rsp_pixel_char;
   logic                       rsp_outside_canvas;
   logic                       csr_write_enable   = 1'b0;
   logic [CSR_INDEX_W-1:0]     csr_index          = '0;
   logic [CSR_DATA_W-1:0]      csr_write_data     = '0;

   int error_count;
   int reads_pending;
   int canvas_cols;
   int canvas_rows;
   int cycle_count = 0;

   // pixels holding a defined character, and one of them that is known
   bit pixel_written [DEPTH];
   bit have_known = 1'b0;
   int known_col;
   int known_row;

   bit gaps_on = 1'b1;
   int clears_sent = 0;
   int draws_sent = 0;
   int reads_sent = 0;
   int settings_used = 1;

   circle_rasterizer_canvas_core DUT (
      .clock, .reset, .start, .busy,
      .req_cmd, .req_center_x, .req_center_y, .req_radius, .req_draw_char,
      .req_read_col, .req_read_row,
      .rsp_valid, .rsp_pixel_char, .rsp_outside_canvas,
      .csr_write_enable, .csr_index, .csr_write_data
   );

   circle_canvas_checker canvas_check (
      .clock, .reset, .start, .busy,
      .req_cmd, .req_center_x, .req_center_y, .req_radius, .req_draw_char,
      .req_read_col, .req_read_row,
      .rsp_valid, .rsp_pixel_char, .rsp_outside_canvas,
      .csr_write_enable, .csr_index, .csr_write_data,
      .error_count, .reads_pending, .canvas_cols, .canvas_rows
   );

   // clock and cycle limit
   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d reads pending", cycle_count, reads_pending);
      $display("TEST FAILED");
      $finish;
   end

   function automatic canvas_command make_cmd(input cmd_type op, input int cx, input int cy,
                                              input int rad, input int ch,
                                              input int col, input int row);
      canvas_command c;
      c.cmd       = op;
      c.center_x  = cx[COORD_W-1:0];
      c.center_y  = cy[COORD_W-1:0];
      c.radius    = rad[RADIUS_W-1:0];
      c.draw_char = ch[CHAR_W-1:0];
      c.read_col  = col[SIDE_W-1:0];
      c.read_row  = row[SIDE_W-1:0];
      return c;
   endfunction

   function automatic canvas_command random_fields();
      canvas_command c;
      c.cmd       = cmd_type'($urandom_range(0, 3));
      c.center_x  = COORD_W'($urandom());
      c.center_y  = COORD_W'($urandom());
      c.radius    = RADIUS_W'($urandom());
      c.draw_char = CHAR_W'($urandom());
      c.read_col  = SIDE_W'($urandom());
      c.read_row  = SIDE_W'($urandom());
      return c;
   endfunction

   // one command transfer, with random gaps before it
   task automatic send_command(input canvas_command c);
      int px;
      int py;
      while (gaps_on && $urandom_range(0, 99) < 21) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start         <= 1'b1;
      req_cmd       <= c.cmd;
      req_center_x  <= c.center_x;
      req_center_y  <= c.center_y;
      req_radius    <= c.radius;
      req_draw_char <= c.draw_char;
      req_read_col  <= c.read_col;
      req_read_row  <= c.read_row;
      do @(posedge clock); while (busy);
      // track which pixels now hold a defined character
      case (c.cmd)
         CMD_CLEAR: begin
            for (int row = 0; row < canvas_rows; row++)
               for (int col = 0; col < canvas_cols; col++)
                  pixel_written[row * MAX_SIDE + col] = 1'b1;
            have_known = 1'b1;
            known_col  = 0;
            known_row  = 0;
            clears_sent++;
         end
         CMD_FILL: begin
            // a whole-pixel centre inside the canvas is always painted
            px = c.center_x >>> FRAC_BITS;
            py = c.center_y >>> FRAC_BITS;
            if (c.center_x[FRAC_BITS-1:0] == '0 && c.center_y[FRAC_BITS-1:0] == '0 &&
                px >= 0 && py >= 0 && px < canvas_cols && py < canvas_rows) begin
               pixel_written[py * MAX_SIDE + px] = 1'b1;
               have_known = 1'b1;
               known_col  = px;
               known_row  = py;
            end
            draws_sent++;
         end
         CMD_OUTLINE: draws_sent++;
         default:     reads_sent++;
      endcase
   endtask

   // wait until the block is idle and every read result has come
   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (busy || reads_pending != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      canvas_command c;
      int            random_done;
      int            phase;
      int            pick;
      int            side_a;
      int            side_b;
      int            cols_new;
      int            rows_new;
      int            items;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset size: a fill before any clear, then a full clear
      send_command(make_cmd(CMD_FILL, 10 * ONE_FIX, 20 * ONE_FIX, 0, "C", 0, 0));
      send_command(make_cmd(CMD_READ, 0, 0, 0, 0, 10, 20));
      send_command(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
      send_command(make_cmd(CMD_READ, 0, 0, 0, 0, 255, 255));
      send_command(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0));

      // one row: width above the store size, height zero
      settle();
      write_register(CSR_WIDTH, '1);
      write_register(CSR_HEIGHT, '0);
      write_register(CSR_BACKGROUND, 9'h0FF);
      settings_used++;
      send_command(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
      send_command(make_cmd(CMD_READ, 0, 0, 0, 0, 255, 0));
      send_command(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 1));
      // ring of radius exactly one
      send_command(make_cmd(CMD_OUTLINE, 128 * ONE_FIX, 0, ONE_FIX, "c", 0, 0));
      send_command(make_cmd(CMD_READ, 0, 0, 0, 0, 127, 0));
      send_command(make_cmd(CMD_READ, 0, 0, 0, 0, 130, 0));
      // largest radius from the most negative centre, centre at the far corner
      send_command(make_cmd(CMD_OUTLINE, -524288, -524288, 1048575, 0, 0, 0));
      send_command(make_cmd(CMD_FILL, 524287, 524287, 0, 0, 0, 0));
      send_command(make_cmd(CMD_READ, 0, 0, 0, 0, 200, 0));

      // one column: width zero, height above the store size
      settle();
      write_register(CSR_WIDTH, '0);
      write_register(CSR_HEIGHT, 9'd300);
      write_register(CSR_BACKGROUND, '0);
      write_register(CSR_SPARE, '1);
      settings_used++;
      send_command(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
      send_command(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 255));
      send_command(make_cmd(CMD_READ, 0, 0, 0, 0, 1, 0));
      // half-pixel centre: radius just reaching the pixel, then just short of it
      send_command(make_cmd(CMD_FILL, ONE_FIX / 2, 100 * ONE_FIX + ONE_FIX / 2, 182, "C", 0, 0));
      send_command(make_cmd(CMD_FILL, ONE_FIX / 2, 100 * ONE_FIX + ONE_FIX / 2, 181, "c", 0, 0));
      send_command(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 100));
      send_command(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 101));
      // ring with radius below one has no hole
      send_command(make_cmd(CMD_OUTLINE, 0, 50 * ONE_FIX, ONE_FIX / 2, "c", 0, 0));
      send_command(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 50));

      // random phases, each with its own canvas setting
      random_done = 0;
      phase       = 0;
      while (random_done < RANDOM_ITEMS) begin
         settle();
         pick   = $urandom_range(0, 9);
         side_a = $urandom_range(0, 3);
         case (side_a)
            0:       side_b = 0;
            1:       side_b = MAX_SIDE;
            2:       side_b = 300;
            default: side_b = 511;
         endcase
         if (pick == 0) begin
            cols_new = side_b;
            rows_new = $urandom_range(0, 3);
         end else if (pick == 1) begin
            cols_new = $urandom_range(0, 3);
            rows_new = side_b;
         end else begin
            cols_new = $urandom_range(1, 16);
            rows_new = $urandom_range(1, 16);
         end
         write_register(CSR_WIDTH, CSR_DATA_W'(cols_new));
         write_register(CSR_HEIGHT, CSR_DATA_W'(rows_new));
         write_register(CSR_BACKGROUND, CSR_DATA_W'($urandom_range(0, 255)));
         if ($urandom_range(0, 4) == 0) write_register(CSR_SPARE, CSR_DATA_W'($urandom()));
         settings_used++;
         // one phase runs without any gaps
         gaps_on = (phase != 1);
         // mostly start from a clean canvas, sometimes keep the old content
         if (phase == 0 || $urandom_range(0, 3) != 0) begin
            c     = random_fields();
            c.cmd = CMD_CLEAR;
            send_command(c);
            random_done++;
         end

         items = $urandom_range(8, 20);
         for (int k = 0; k < items; k++) begin
            c    = random_fields();
            pick = $urandom_range(0, 99);
            if (pick < 45)      c.cmd = CMD_READ;
            else if (pick < 65) c.cmd = CMD_OUTLINE;
            else if (pick < 90) c.cmd = CMD_FILL;
            else                c.cmd = CMD_CLEAR;

            if (c.cmd == CMD_OUTLINE || c.cmd == CMD_FILL) begin
               // centre near the canvas with a random fraction, else anywhere
               if ($urandom_range(0, 4) != 0) begin
                  c.center_x = COORD_W'((int'($urandom_range(0, canvas_cols + 5)) - 3) * ONE_FIX
                                        + int'($urandom_range(0, ONE_FIX - 1)));
                  c.center_y = COORD_W'((int'($urandom_range(0, canvas_rows + 5)) - 3) * ONE_FIX
                                        + int'($urandom_range(0, ONE_FIX - 1)));
               end
               pick = $urandom_range(0, 99);
               if (pick < 70)
                  c.radius = RADIUS_W'($urandom_range(0,
                                       (canvas_cols + canvas_rows) * ONE_FIX / 2));
               else if (pick < 85)
                  c.radius = RADIUS_W'($urandom_range(0, 2 * ONE_FIX));
            end

            if (c.cmd == CMD_READ) begin
               if ($urandom_range(0, 9) < 7) begin
                  c.read_col = SIDE_W'($urandom_range(0, canvas_cols - 1));
                  c.read_row = SIDE_W'($urandom_range(0, canvas_rows - 1));
               end
               // never read a pixel that holds no defined character
               if (int'(c.read_col) < canvas_cols && int'(c.read_row) < canvas_rows &&
                   !pixel_written[int'(c.read_row) * MAX_SIDE + int'(c.read_col)]) begin
                  if (have_known) begin
                     c.read_col = SIDE_W'(known_col);
                     c.read_row = SIDE_W'(known_row);
                  end else begin
                     c.cmd = CMD_FILL;
                  end
               end
            end

            send_command(c);
            random_done++;
         end
         phase++;
      end

      // drain and verdict
      settle();
      repeat (8) @(posedge clock);
      $display("ran %0d clears, %0d circle draws and %0d pixel reads", clears_sent,
               draws_sent, reads_sent);
      $display("over %0d canvas settings, %0d mismatches", settings_used, error_count);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
